// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// File: hw/rtl/fat_snf_pkg.sv
// Shared constants, types and character checks of the 8.3 short-name formatter.
`default_nettype none
package fat_snf_pkg;
   localparam int NAME_LEN = 11;
   localparam int CNT_W = $clog2(NAME_LEN);

   localparam logic [CNT_W-1:0] BASE_LEN  = CNT_W'(8);
   localparam logic [CNT_W-1:0] BASE_LAST = CNT_W'(7);
   localparam logic [CNT_W-1:0] FULL_LAST = CNT_W'(NAME_LEN - 1);

   localparam logic [7:0] PRINT_LO   = 8'h21;
   localparam logic [7:0] PRINT_HI   = 8'h7E;
   localparam logic [7:0] SPACE_CODE = 8'h20;
   localparam logic [7:0] DOT_CODE   = 8'h2E;
   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] LOWER_Z    = 8'h7A;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   typedef logic [NAME_LEN-1:0][7:0] name_array_type;

   // Hand-off of a finished name from the character stage to the emitter.
   typedef struct packed {
      logic           load;
      logic           valid;
      name_array_type bytes;
   } name_load_type;

   function automatic logic is_bad_char(input logic [7:0] c);
      logic bad;
      case (c) inside
         8'h7C, 8'h3C, 8'h3E, 8'h5E, 8'h2B, 8'h3D, 8'h3F, 8'h2F,
         8'h5B, 8'h5D, 8'h3B, 8'h2C, 8'h2A, 8'h22, 8'h5C: bad = 1'b1;
         default: bad = 1'b0;
      endcase
      return bad;
   endfunction
endpackage
`default_nettype wire

// File: hw/rtl/fat_short_name_formatter.sv
// Top level of the FAT 8.3 short-name formatter.
//
//   channel | direction | ports                                   | per request
//   req     | in        | req_valid req_stall req_ch req_is_end   | one character or end mark
//   rsp     | out       | rsp_valid rsp_stall rsp_name_byte       | one name byte
//           |           | rsp_name_valid rsp_last_byte            |
//
// One character request per cycle; each updates the name register in that cycle.
// An end request hands the 11-byte name to the emitter and clears the name
// register, so the next name's characters flow in while the old one drains.
// The emitter sends 11 byte requests, one per cycle when rsp_stall is low.
// An end request is stalled only while the emitter still holds bytes of the
// previous name (released in the cycle its last byte is taken).
// Synchronous active-high reset: name register to spaces, emitter empty.
`default_nettype none
`include "assert_macros.svh"
module fat_short_name_formatter import fat_snf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_is_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_name_byte,
   output logic             rsp_name_valid,
   output logic             rsp_last_byte
);
   name_load_type load;
   logic          emit_free;
   logic          req_accept;

   // characters never wait; an end mark waits for a free emitter
   assign req_stall  = req_is_end && !emit_free;
   assign req_accept = req_valid && !req_stall;

   fat_snf_char u_char (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .ch     (req_ch),
      .is_end (req_is_end),
      .load   (load)
   );

   fat_snf_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .free           (emit_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_name_byte  (rsp_name_byte),
      .rsp_name_valid (rsp_name_valid),
      .rsp_last_byte  (rsp_last_byte)
   );

   // no new name may land on one that still has bytes to send
   `ASSERT_NEVER(a_no_overrun, clock, reset, load.load && rsp_valid && !(!rsp_stall && rsp_last_byte), "name loaded over pending bytes")
   // an accepted end mark starts a fresh run of bytes
   `ASSERT_PROP(a_run_starts, clock, reset, req_accept && req_is_end |=> rsp_valid && !rsp_last_byte, "end request did not start output")
   // name_valid holds across the bytes of one run
   `ASSERT_PROP(a_flag_steady, clock, reset, rsp_valid && !rsp_stall && !rsp_last_byte |=> rsp_valid && (rsp_name_valid == $past(rsp_name_valid)), "name_valid changed within a run")
endmodule
`default_nettype wire

// File: hw/rtl/fat_snf_char.sv
// Character stage: checks each character and builds the 11-byte name.
`default_nettype none
module fat_snf_char import fat_snf_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic [7:0]    ch,
   input  wire logic          is_end,
   output name_load_type      load
);
   name_array_type    name_store_ff, name_store_in;
   logic [CNT_W-1:0]  write_pos_ff, write_pos_in;
   logic              dot_seen_ff, dot_seen_in;
   logic              failed_ff, failed_in;

   logic [7:0]        up_ch;
   logic [CNT_W-1:0]  limit;
   logic              reject;

   always_comb begin
      up_ch = (ch inside {[LOWER_A:LOWER_Z]}) ? ch - CASE_SHIFT : ch;
      limit = dot_seen_ff ? FULL_LAST : BASE_LAST;
      reject = is_bad_char(ch) || (write_pos_ff > limit) ||
               (ch < PRINT_LO) || (ch > PRINT_HI);

      name_store_in = name_store_ff;
      write_pos_in  = write_pos_ff;
      dot_seen_in   = dot_seen_ff;
      failed_in     = failed_ff;

      load.load  = accept && is_end;
      load.valid = !failed_ff && (name_store_ff[0] != SPACE_CODE);
      load.bytes = name_store_ff;

      if (accept && is_end) begin
         // name leaves for the emitter; start over
         name_store_in = {NAME_LEN{SPACE_CODE}};
         write_pos_in  = '0;
         dot_seen_in   = 1'b0;
         failed_in     = 1'b0;
      end else if (accept && !failed_ff) begin
         if (ch == DOT_CODE) begin
            if (dot_seen_ff) begin
               failed_in = 1'b1;
            end else begin
               dot_seen_in  = 1'b1;
               write_pos_in = BASE_LEN;
            end
         end else if (reject) begin
            failed_in = 1'b1;
         end else begin
            // write_pos is at most FULL_LAST here
            name_store_in[write_pos_ff] = up_ch;
            write_pos_in = write_pos_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_store_ff <= {NAME_LEN{SPACE_CODE}};
         write_pos_ff  <= '0;
         dot_seen_ff   <= 1'b0;
         failed_ff     <= 1'b0;
      end else begin
         name_store_ff <= name_store_in;
         write_pos_ff  <= write_pos_in;
         dot_seen_ff   <= dot_seen_in;
         failed_ff     <= failed_in;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/fat_snf_emit.sv
// Emitter: holds a finished name and shifts it out one byte per request.
`default_nettype none
module fat_snf_emit import fat_snf_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire name_load_type load,
   output logic               free,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [7:0]         rsp_name_byte,
   output logic               rsp_name_valid,
   output logic               rsp_last_byte
);
   name_array_type    buf_ff, buf_in;
   logic              nvalid_ff, nvalid_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              take, done;

   always_comb begin
      take = busy_ff && !rsp_stall;
      done = take && (cnt_ff == FULL_LAST);
      free = !busy_ff || done;

      buf_in    = buf_ff;
      nvalid_in = nvalid_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;

      if (load.load) begin
         buf_in    = load.bytes;
         nvalid_in = load.valid;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (take) begin
         buf_in    = {SPACE_CODE, buf_ff[NAME_LEN-1:1]};
         cnt_in    = cnt_ff + CNT_W'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff    <= buf_in;
      nvalid_ff <= nvalid_in;
   end

   assign rsp_valid      = busy_ff;
   assign rsp_name_byte  = buf_ff[0];
   assign rsp_name_valid = nvalid_ff;
   assign rsp_last_byte  = (cnt_ff == FULL_LAST);
endmodule
`default_nettype wire
